// ===== rtl/lwc_pkg.sv =====
// Shared types, constants and the outcode function of the line window clipper.
// No dependencies; imported by lwc_ratio and line_window_clipper.
package lwc_pkg;

   localparam int SCREEN_ROWS = 192;
   localparam int TOP_OFFSET  = 192;
   localparam int MAX_PASSES  = 8;

   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_W       = 16;
   localparam int FIELD_W     = 16;

   localparam int COORD_W   = 18;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int FRAC_BITS = 8;
   localparam int QUOT_W    = FRAC_BITS + 1;
   localparam int T_W       = QUOT_W + 1;
   localparam int PROD_W    = T_W + DIFF_W;
   localparam int SHIFT_W   = PROD_W - FRAC_BITS;
   localparam int STEP_W    = $clog2(QUOT_W);
   localparam int PASS_W    = $clog2(MAX_PASSES + 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   localparam coord_type ONE_C  = COORD_W'(1);
   localparam coord_type ROWS_C = COORD_W'(SCREEN_ROWS);
   localparam coord_type TOP_C  = COORD_W'(TOP_OFFSET);

   localparam logic [3:0] OC_BOTTOM = 4'b0001;
   localparam logic [3:0] OC_TOP    = 4'b0010;
   localparam logic [3:0] OC_RIGHT  = 4'b0100;
   localparam logic [3:0] OC_LEFT   = 4'b1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CLIP_LEFT   = 3'd0,
      REG_CLIP_TOP    = 3'd1,
      REG_CLIP_WIDTH  = 3'd2,
      REG_CLIP_HEIGHT = 3'd3,
      REG_PORT_LEFT   = 3'd4,
      REG_PORT_TOP    = 3'd5,
      REG_PORT_WIDTH  = 3'd6,
      REG_PORT_HEIGHT = 3'd7
   } reg_index_type;

   localparam logic [CSR_W-1:0] CSR_RESET [NUM_REGS] = '{
      16'd0, 16'd0, 16'd256, 16'd192, 16'd0, 16'd0, 16'd256, 16'd192
   };

   typedef struct packed {
      coord_type xmin;
      coord_type ymin;
      coord_type xmax;
      coord_type ymax;
   } win_type;

   typedef struct packed {
      logic     go;
      diff_type num;
      diff_type den;
      diff_type span;
   } ratio_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SHIFT_W-1:0]  value;
   } ratio_rsp_type;

   function automatic logic [3:0] outcode(coord_type x, coord_type y, win_type w);
      logic [3:0] c;
      c = '0;
      if (y > w.ymax) c = c | OC_BOTTOM;
      if (y < w.ymin) c = c | OC_TOP;
      if (x > w.xmax) c = c | OC_RIGHT;
      if (x < w.xmin) c = c | OC_LEFT;
      return c;
   endfunction

endpackage

// ===== rtl/lwc_ratio.sv =====
// Shared ratio unit: floor(trunc(num*256/den) * span / 256), bit-serial divide then one multiply.
// Depends on lwc_pkg.
module lwc_ratio import lwc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ratio_req_type req,
   output ratio_rsp_type rsp
);

   typedef enum logic [2:0] {
      RS_IDLE = 3'b001,
      RS_DIV  = 3'b010,
      RS_MUL  = 3'b100
   } rstate_type;

   rstate_type               state_ff, state_in;
   logic [DIFF_W-1:0]        rem_ff, rem_in;
   logic [DIFF_W-1:0]        div_ff, div_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   diff_type                 span_ff, span_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     done_ff, done_in;

   always_comb begin
      logic [DIFF_W:0]       trial;
      logic                  ge;
      logic signed [T_W-1:0] t;
      state_in = state_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      span_in  = span_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      trial    = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      ge       = trial >= {1'b0, div_ff};
      t        = '0;
      unique case (state_ff)
         RS_IDLE: begin
            if (req.go) begin
               rem_in   = req.num[DIFF_W-1] ? DIFF_W'(-req.num) : DIFF_W'(req.num);
               div_in   = req.den[DIFF_W-1] ? DIFF_W'(-req.den) : DIFF_W'(req.den);
               neg_in   = req.num[DIFF_W-1] ^ req.den[DIFF_W-1];
               zero_in  = (req.den == '0);
               span_in  = req.span;
               step_in  = '0;
               quot_in  = '0;
               state_in = RS_DIV;
            end
         end
         RS_DIV: begin
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            rem_in  = ge ? DIFF_W'(trial - {1'b0, div_ff}) : DIFF_W'(trial);
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = RS_MUL;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         RS_MUL: begin
            if (zero_ff) begin
               t = '0;
            end else if (neg_ff) begin
               t = -$signed({1'b0, quot_ff});
            end else begin
               t = $signed({1'b0, quot_ff});
            end
            prod_in  = t * span_ff;
            done_in  = 1'b1;
            state_in = RS_IDLE;
         end
         default: state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      span_ff <= span_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = $signed(prod_ff[PROD_W-1:FRAC_BITS]);

endmodule

// ===== rtl/line_window_clipper.sv =====
// Line window clipper top level: window set-up, outcode sequencer and result register.
// Depends on lwc_pkg and lwc_ratio.
// A line is taken when start is high and busy is low; busy stays high until the result
// comes out. The result is shown for exactly one cycle with rsp_strobe high and must be taken
// then, since nothing can hold it. When the window itself is rejected, the strobe follows the
// window set-up with no clip pass; otherwise a line takes one pass per edge intersection
// needed (0 to 8). Each pass costs one trip through the shared ratio unit: nine divide
// steps, one multiply and the update. A new line may be started in the cycle that shows
// the result.
module line_window_clipper import lwc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [FIELD_W-1:0] req_start_x,
   input  logic signed [FIELD_W-1:0] req_start_y,
   input  logic signed [FIELD_W-1:0] req_end_x,
   input  logic signed [FIELD_W-1:0] req_end_y,
   input  logic [FIELD_W-1:0]        req_line_colour,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   output logic                      rsp_strobe,
   output logic                      rsp_visible,
   output logic signed [FIELD_W-1:0] rsp_out_start_x,
   output logic signed [FIELD_W-1:0] rsp_out_start_y,
   output logic signed [FIELD_W-1:0] rsp_out_end_x,
   output logic signed [FIELD_W-1:0] rsp_out_end_y,
   output logic [FIELD_W-1:0]        rsp_out_colour
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_WIN_X  = 8'b0000_0010,
      ST_WIN_Y  = 8'b0000_0100,
      ST_ADJUST = 8'b0000_1000,
      ST_CODES  = 8'b0001_0000,
      ST_TEST   = 8'b0010_0000,
      ST_RATIO  = 8'b0100_0000,
      ST_APPLY  = 8'b1000_0000
   } state_type;

   logic [CSR_W-1:0]   csr_ff [NUM_REGS];

   state_type          state_ff, state_in;
   coord_type          x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [3:0]         c1_ff, c1_in, c2_ff, c2_in;
   win_type            win_ff, win_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic [FIELD_W-1:0] colour_ff, colour_in;
   logic               horiz_ff, horiz_in;
   logic               end2_ff, end2_in;
   coord_type          bound_ff, bound_in;
   coord_type          base_ff, base_in;

   logic               strobe_ff, strobe_in;
   logic               visible_ff, visible_in;
   logic [FIELD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [FIELD_W-1:0] oc_ff, oc_in;

   ratio_req_type      ratio_req;
   ratio_rsp_type      ratio_rsp;

   lwc_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .req   (ratio_req),
      .rsp   (ratio_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            csr_ff[i] <= CSR_RESET[i];
         end
      end else if (csr_we) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      coord_type  lo_a, lo_b, hi_a, hi_b, ymax_c, nval, nx, ny;
      logic [3:0] co;
      logic       finish, fin_vis;
      state_in   = state_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      x2_in      = x2_ff;
      y2_in      = y2_ff;
      c1_in      = c1_ff;
      c2_in      = c2_ff;
      win_in     = win_ff;
      pass_in    = pass_ff;
      colour_in  = colour_ff;
      horiz_in   = horiz_ff;
      end2_in    = end2_ff;
      bound_in   = bound_ff;
      base_in    = base_ff;
      strobe_in  = 1'b0;
      visible_in = visible_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      ex_in      = ex_ff;
      ey_in      = ey_ff;
      oc_in      = oc_ff;
      ratio_req  = '0;
      lo_a       = '0;
      lo_b       = '0;
      hi_a       = '0;
      hi_b       = '0;
      ymax_c     = win_ff.ymax;
      nval       = '0;
      nx         = '0;
      ny         = '0;
      co         = '0;
      finish     = 1'b0;
      fin_vis    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x1_in     = COORD_W'(req_start_x);
               y1_in     = COORD_W'(req_start_y);
               x2_in     = COORD_W'(req_end_x);
               y2_in     = COORD_W'(req_end_y);
               colour_in = req_line_colour;
               pass_in   = '0;
               state_in  = ST_WIN_X;
            end
         end
         ST_WIN_X: begin
            lo_a = COORD_W'($signed(csr_ff[REG_CLIP_LEFT]));
            lo_b = COORD_W'($signed(csr_ff[REG_PORT_LEFT]));
            hi_a = lo_a + $signed({2'b00, csr_ff[REG_CLIP_WIDTH]}) - ONE_C;
            hi_b = lo_b + $signed({2'b00, csr_ff[REG_PORT_WIDTH]}) - ONE_C;
            win_in.xmin = (lo_a > lo_b) ? lo_a : lo_b;
            win_in.xmax = (hi_a < hi_b) ? hi_a : hi_b;
            state_in    = ST_WIN_Y;
         end
         ST_WIN_Y: begin
            lo_a = COORD_W'($signed(csr_ff[REG_CLIP_TOP]));
            lo_b = COORD_W'($signed(csr_ff[REG_PORT_TOP]));
            hi_a = lo_a + $signed({2'b00, csr_ff[REG_CLIP_HEIGHT]}) - ONE_C;
            hi_b = lo_b + $signed({2'b00, csr_ff[REG_PORT_HEIGHT]}) - ONE_C;
            win_in.ymin = (lo_a > lo_b) ? lo_a : lo_b;
            win_in.ymax = (hi_a < hi_b) ? hi_a : hi_b;
            state_in    = ST_ADJUST;
         end
         ST_ADJUST: begin
            if (win_ff.ymin >= TOP_C) begin
               win_in.ymin = win_ff.ymin - TOP_C;
               win_in.ymax = win_ff.ymax - TOP_C;
            end
            state_in = ST_CODES;
         end
         ST_CODES: begin
            if (win_ff.ymin > ROWS_C) begin
               finish = 1'b1;
            end else begin
               ymax_c      = (win_ff.ymax >= ROWS_C) ? ROWS_C - ONE_C : win_ff.ymax;
               win_in.ymax = ymax_c;
               if (win_ff.xmax < win_ff.xmin || ymax_c < win_ff.ymin) begin
                  finish = 1'b1;
               end else begin
                  c1_in    = outcode(x1_ff, y1_ff, win_in);
                  c2_in    = outcode(x2_ff, y2_ff, win_in);
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            priority if ((c1_ff | c2_ff) == '0) begin
               finish  = 1'b1;
               fin_vis = 1'b1;
            end else if ((c1_ff & c2_ff) != '0) begin
               finish = 1'b1;
            end else if (pass_ff >= PASS_W'(MAX_PASSES)) begin
               finish = 1'b1;
            end else begin
               co      = (c1_ff != '0) ? c1_ff : c2_ff;
               end2_in = (c1_ff == '0);
               priority if ((co & OC_BOTTOM) != '0) begin
                  ratio_req.num  = DIFF_W'(win_ff.ymax) - DIFF_W'(y1_ff);
                  ratio_req.den  = DIFF_W'(y2_ff) - DIFF_W'(y1_ff);
                  ratio_req.span = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
                  base_in        = x1_ff;
                  bound_in       = win_ff.ymax;
                  horiz_in       = 1'b1;
               end else if ((co & OC_TOP) != '0) begin
                  ratio_req.num  = DIFF_W'(win_ff.ymin) - DIFF_W'(y1_ff);
                  ratio_req.den  = DIFF_W'(y2_ff) - DIFF_W'(y1_ff);
                  ratio_req.span = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
                  base_in        = x1_ff;
                  bound_in       = win_ff.ymin;
                  horiz_in       = 1'b1;
               end else if ((co & OC_RIGHT) != '0) begin
                  ratio_req.num  = DIFF_W'(win_ff.xmax) - DIFF_W'(x1_ff);
                  ratio_req.den  = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
                  ratio_req.span = DIFF_W'(y2_ff) - DIFF_W'(y1_ff);
                  base_in        = y1_ff;
                  bound_in       = win_ff.xmax;
                  horiz_in       = 1'b0;
               end else begin
                  ratio_req.num  = DIFF_W'(win_ff.xmin) - DIFF_W'(x1_ff);
                  ratio_req.den  = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
                  ratio_req.span = DIFF_W'(y2_ff) - DIFF_W'(y1_ff);
                  base_in        = y1_ff;
                  bound_in       = win_ff.xmin;
                  horiz_in       = 1'b0;
               end
               ratio_req.go = 1'b1;
               state_in     = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (ratio_rsp.done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            nval = base_ff + COORD_W'(ratio_rsp.value);
            nx   = horiz_ff ? nval : bound_ff;
            ny   = horiz_ff ? bound_ff : nval;
            if (end2_ff) begin
               x2_in = nx;
               y2_in = ny;
               c2_in = outcode(nx, ny, win_ff);
            end else begin
               x1_in = nx;
               y1_in = ny;
               c1_in = outcode(nx, ny, win_ff);
            end
            pass_in  = pass_ff + PASS_W'(1);
            state_in = ST_TEST;
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         strobe_in  = 1'b1;
         visible_in = fin_vis;
         sx_in      = fin_vis ? x1_ff[FIELD_W-1:0] : '0;
         sy_in      = fin_vis ? y1_ff[FIELD_W-1:0] : '0;
         ex_in      = fin_vis ? x2_ff[FIELD_W-1:0] : '0;
         ey_in      = fin_vis ? y2_ff[FIELD_W-1:0] : '0;
         oc_in      = fin_vis ? colour_ff : '0;
         state_in   = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         pass_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         pass_ff   <= pass_in;
      end
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      c1_ff      <= c1_in;
      c2_ff      <= c2_in;
      win_ff     <= win_in;
      colour_ff  <= colour_in;
      horiz_ff   <= horiz_in;
      end2_ff    <= end2_in;
      bound_ff   <= bound_in;
      base_ff    <= base_in;
      visible_ff <= visible_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      ex_ff      <= ex_in;
      ey_ff      <= ey_in;
      oc_ff      <= oc_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_visible     = visible_ff;
   assign rsp_out_start_x = $signed(sx_ff);
   assign rsp_out_start_y = $signed(sy_ff);
   assign rsp_out_end_x   = $signed(ex_ff);
   assign rsp_out_end_y   = $signed(ey_ff);
   assign rsp_out_colour  = oc_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted line did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one beat");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_visible |-> rsp_out_start_x == '0 && rsp_out_start_y == '0 &&
         rsp_out_end_x == '0 && rsp_out_end_y == '0 && rsp_out_colour == '0)
      else $error("rejected line carries a non-zero payload");

   a_apply_after_ratio: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> $past(ratio_rsp.done))
      else $error("endpoint update without a finished ratio");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PASS_W'(MAX_PASSES))
      else $error("clip pass count beyond limit");

endmodule
